>>> rtl/core/dac_sample_ring_fifo_top_defines.svh
// Assertion macros used by the ring FIFO top module.
`ifndef DAC_SAMPLE_RING_FIFO_TOP_DEFINES_SVH
`define DAC_SAMPLE_RING_FIFO_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define DSRF_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("dsrf check failed");

`define DSRF_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("dsrf check failed");

`else

`define DSRF_ASSERT_IMPL(label, clk, rst_n, cond, prop)

`define DSRF_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

>>> rtl/core/dsrf_pkg.sv
`timescale 1ns / 1ps

package dsrf_pkg;

    localparam int DEPTH      = 256;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = PTR_W + 1;
    localparam int CFG_W      = 9;
    localparam int CMP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int SAMPLE_W   = 16;
    localparam int FILL_W     = 8;
    localparam int FILL_CMP_W = (SUM_W > FILL_W) ? SUM_W : FILL_W;
    localparam int UNDER_W    = 16;
    localparam int MIN_DEPTH  = 2;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam logic REG_DEPTH_SEL = 1'b0;

    typedef struct packed {
        logic                       req_type;
        logic signed [SAMPLE_W-1:0] sample_in;
    } dsrf_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] dac_sample;
        logic                       dac_strobe;
        logic                       push_accepted;
        logic [FILL_W-1:0]          fill_level;
        logic [UNDER_W-1:0]         underrun_total;
    } dsrf_out_t;

    function automatic logic [CNT_W-1:0] clamp_depth(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        if (w < CMP_W'(MIN_DEPTH))
            return CNT_W'(MIN_DEPTH);
        else if (w > CMP_W'(DEPTH))
            return CNT_W'(DEPTH);
        else
            return CNT_W'(w);
    endfunction

    localparam logic [CNT_W-1:0] DEPTH_RST = clamp_depth(CFG_W'(DEPTH));

endpackage

>>> rtl/core/dac_sample_ring_fifo_top.sv
// Ring FIFO of signed 16-bit samples feeding a DAC.
// Item channel (item_valid/item_stall/item): a push stores item.sample_in, a
// tick plays the oldest stored sample. Every request gives exactly one result
// on the result channel (result_valid/result_stall/result).
// A push into a full ring is dropped with push_accepted low. A tick on an
// empty ring repeats the last played sample and bumps the saturating
// underrun count.
// result_valid rises once the request has left the read stage: the accepting edge
// starts the sample memory read and loads the read stage, which moves into the
// output register once that is free. One request is accepted every cycle while
// item_stall is low; the sample memory does at most one write or one read per request.
// When result_stall is high, one result waits in the output register and one
// more request is taken into the memory-read stage; item_stall then rises
// until the output moves again.
// Reset clears both pointers, the last played sample, the underrun count and
// sets the ring depth to its full size. Writing depth_in_use over the APB port
// (byte address 0) empties the ring; do it only while the block is idle.
`timescale 1ns / 1ps
`include "dac_sample_ring_fifo_top_defines.svh"

module dac_sample_ring_fifo_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  dsrf_pkg::dsrf_in_t            item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output dsrf_pkg::dsrf_out_t           result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dsrf_pkg::PADDR_W-1:0]  paddr,
    input  logic [dsrf_pkg::PDATA_W-1:0]  pwdata,
    output logic [dsrf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    import dsrf_pkg::*;

    typedef struct packed {
        logic                       use_mem;
        logic signed [SAMPLE_W-1:0] played;
        logic                       strobe;
        logic                       accepted;
        logic [FILL_W-1:0]          fill;
        logic [UNDER_W-1:0]         underrun;
    } dsrf_s1_t;

    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    play_ptr_reg, play_ptr_next;
    logic [CNT_W-1:0]    depth_reg, depth_next;
    logic [SAMPLE_W-1:0] last_played_reg, last_played_next;
    logic [UNDER_W-1:0]  underrun_reg, underrun_next;
    logic                s1_valid_reg, s1_valid_next;
    dsrf_s1_t            s1_reg, s1_next;
    logic                o_valid_reg, o_valid_next;
    dsrf_out_t           o_reg, o_next;

    logic                o_free;
    logic                s1_adv;
    logic                take;
    logic                cfg_wr;
    logic [PTR_W-1:0]    wr_succ;
    logic [PTR_W-1:0]    play_succ;
    logic                full;
    logic                empty;
    logic                push_ok;
    logic                tick_mem;
    logic                tick_under;
    logic [SAMPLE_W-1:0] lp_cur;
    logic [SUM_W-1:0]    diff;
    logic [FILL_W-1:0]   fill_val;
    logic [SAMPLE_W-1:0] ram_rd_data;

    function automatic logic [PTR_W-1:0] next_slot(
        input logic [PTR_W-1:0] p,
        input logic [CNT_W-1:0] d
    );
        logic [SUM_W-1:0] n;
        n = SUM_W'(p) + SUM_W'(1);
        if (n >= SUM_W'(d))
            return '0;
        else
            return n[PTR_W-1:0];
    endfunction

    assign o_free     = !o_valid_reg || !result_stall;
    assign s1_adv     = s1_valid_reg && o_free;
    assign item_stall = s1_valid_reg && !o_free;
    assign take       = item_valid && !item_stall;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DEPTH_SEL);
    assign pready = 1'b1;
    assign prdata = PDATA_W'(depth_reg);

    assign wr_succ    = next_slot(wr_ptr_reg, depth_reg);
    assign play_succ  = next_slot(play_ptr_reg, depth_reg);
    assign full       = (wr_succ == play_ptr_reg);
    assign empty      = (wr_ptr_reg == play_ptr_reg);
    assign push_ok    = take && (item.req_type == REQ_PUSH) && !full;
    assign tick_mem   = take && (item.req_type == REQ_TICK) && !empty;
    assign tick_under = take && (item.req_type == REQ_TICK) && empty;

    // The tick waiting in the read stage is the latest played sample.
    assign lp_cur = (s1_valid_reg && s1_reg.use_mem) ? ram_rd_data : last_played_reg;

    dsrf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (push_ok),
        .wr_addr (wr_ptr_reg),
        .wr_data (item.sample_in),
        .rd_en   (tick_mem),
        .rd_addr (play_ptr_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        wr_ptr_next      = wr_ptr_reg;
        play_ptr_next    = play_ptr_reg;
        depth_next       = depth_reg;
        underrun_next    = underrun_reg;
        last_played_next = lp_cur;

        if (cfg_wr)
        begin
            depth_next    = clamp_depth(pwdata[CFG_W-1:0]);
            wr_ptr_next   = '0;
            play_ptr_next = '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_next = wr_succ;
            end
            if (tick_mem)
            begin
                play_ptr_next = play_succ;
            end
            if (tick_under && (underrun_reg != {UNDER_W{1'b1}}))
            begin
                underrun_next = underrun_reg + UNDER_W'(1);
            end
        end
    end

    // Fill level after this request, capped at the field's maximum.
    always_comb
    begin
        if (wr_ptr_next >= play_ptr_next)
        begin
            diff = SUM_W'(wr_ptr_next) - SUM_W'(play_ptr_next);
        end
        else
        begin
            diff = SUM_W'(wr_ptr_next) + SUM_W'(depth_reg) - SUM_W'(play_ptr_next);
        end

        if (FILL_CMP_W'(diff) > FILL_CMP_W'({FILL_W{1'b1}}))
        begin
            fill_val = {FILL_W{1'b1}};
        end
        else
        begin
            fill_val = FILL_W'(diff);
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        if (take)
        begin
            s1_valid_next    = 1'b1;
            s1_next.use_mem  = tick_mem;
            s1_next.played   = (item.req_type == REQ_TICK) ? lp_cur : '0;
            s1_next.strobe   = (item.req_type == REQ_TICK);
            s1_next.accepted = push_ok;
            s1_next.fill     = fill_val;
            s1_next.underrun = underrun_next;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        o_valid_next = o_valid_reg;
        o_next       = o_reg;
        if (s1_adv)
        begin
            o_valid_next          = 1'b1;
            o_next.dac_sample     = s1_reg.use_mem ? ram_rd_data : s1_reg.played;
            o_next.dac_strobe     = s1_reg.strobe;
            o_next.push_accepted  = s1_reg.accepted;
            o_next.fill_level     = s1_reg.fill;
            o_next.underrun_total = s1_reg.underrun;
        end
        else if (o_valid_reg && !result_stall)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg      <= '0;
            play_ptr_reg    <= '0;
            depth_reg       <= DEPTH_RST;
            last_played_reg <= '0;
            underrun_reg    <= '0;
            s1_valid_reg    <= 1'b0;
            o_valid_reg     <= 1'b0;
        end
        else
        begin
            wr_ptr_reg      <= wr_ptr_next;
            play_ptr_reg    <= play_ptr_next;
            depth_reg       <= depth_next;
            last_played_reg <= last_played_next;
            underrun_reg    <= underrun_next;
            s1_valid_reg    <= s1_valid_next;
            o_valid_reg     <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        o_reg  <= o_next;
    end

    assign result_valid = o_valid_reg;
    assign result       = o_reg;

    `DSRF_ASSERT_IMPL(a_ptr_range, clk, rst_n, 1'b1,
        (CNT_W'(wr_ptr_reg) < depth_reg) && (CNT_W'(play_ptr_reg) < depth_reg))
    `DSRF_ASSERT_NEXT(a_rd_hold, clk, rst_n, s1_valid_reg && s1_reg.use_mem && !s1_adv,
        $stable(ram_rd_data))
    `DSRF_ASSERT_IMPL(a_fill_cap, clk, rst_n, o_valid_reg,
        (CNT_W'(o_reg.fill_level) < depth_reg) && !(o_reg.dac_strobe && o_reg.push_accepted))

endmodule

>>> rtl/core/dsrf_ram.sv
`timescale 1ns / 1ps

module dsrf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> test/tb_dac_sample_ring_fifo_top.sv
`timescale 1ns / 1ps

module tb_dac_sample_ring_fifo_top;

    import dsrf_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int PHASES = 12;
    localparam logic [PADDR_W-1:0] DEPTH_REG_ADDR = PADDR_W'(0);

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic item_valid = 1'b0;
    logic item_stall;
    dsrf_in_t req_item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    dsrf_out_t res_item;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    // Shadow copy of the ring, kept in step with accepted requests.
    logic signed [SAMPLE_W-1:0] ring_mem [0:DEPTH-1];
    int wr_slot = 0;
    int play_slot = 0;
    int ring_depth = DEPTH;
    logic signed [SAMPLE_W-1:0] last_sample = '0;
    logic [UNDER_W-1:0] underruns = '0;

    dsrf_in_t pending_reqs[$];
    dsrf_out_t expected_results[$];

    int error_count = 0;
    int cycle_count = 0;
    int stall_pct = 0;
    int gap_max = 0;
    int burst_left = 0;
    int gap_left = 0;
    int holdoff_ask = 0;
    int holdoff_left = 0;

    int depth_plan [PHASES] = '{3, 0, 511, 1, 300, 255, 17, 5, 256, 2, -1, -1};
    int half_plan [PHASES] = '{45, 45, 280, 45, 60, 280, 60, 45, 60, 45, 60, 60};

    dac_sample_ring_fifo_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (req_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (res_item),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic dsrf_out_t predict_dac_result(input dsrf_in_t req);
        dsrf_out_t r;
        int nxt;
        int fill;
        r = '0;
        if (req.req_type == REQ_PUSH)
        begin
            nxt = (wr_slot + 1 >= ring_depth) ? 0 : wr_slot + 1;
            if (nxt != play_slot)
            begin
                ring_mem[wr_slot] = req.sample_in;
                wr_slot = nxt;
                r.push_accepted = 1'b1;
            end
        end
        else
        begin
            r.dac_strobe = 1'b1;
            if (play_slot != wr_slot)
            begin
                last_sample = ring_mem[play_slot];
                play_slot = (play_slot + 1 >= ring_depth) ? 0 : play_slot + 1;
            end
            else if (underruns != {UNDER_W{1'b1}})
                underruns++;
            r.dac_sample = last_sample;
        end
        fill = (wr_slot >= play_slot) ? wr_slot - play_slot : wr_slot + ring_depth - play_slot;
        r.fill_level = (fill > 255) ? 8'hFF : fill[FILL_W-1:0];
        r.underrun_total = underruns;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Request driver: bursts of back-to-back requests separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                expected_results.push_back(predict_dac_result(req_item));
            if (!(item_valid && item_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req_item <= pending_reqs.pop_front();
                    item_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(16, 1);
                        gap_left = (gap_max == 0) ? 0 : $urandom_range(gap_max);
                    end
                    else
                        burst_left--;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0h", $time, res_item);
                    error_count++;
                end
                else
                begin
                    dsrf_out_t exp_r;
                    exp_r = expected_results.pop_front();
                    check_field("dac_sample", exp_r.dac_sample, res_item.dac_sample);
                    check_field("dac_strobe", exp_r.dac_strobe, res_item.dac_strobe);
                    check_field("push_accepted", exp_r.push_accepted, res_item.push_accepted);
                    check_field("fill_level", exp_r.fill_level, res_item.fill_level);
                    check_field("underrun_total", exp_r.underrun_total,
                                res_item.underrun_total);
                end
            end
            if (holdoff_ask > 0)
            begin
                holdoff_left = holdoff_ask;
                holdoff_ask = 0;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic add_req(input logic kind, input logic signed [SAMPLE_W-1:0] smp);
        dsrf_in_t r;
        r.req_type = kind;
        r.sample_in = smp;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_random(input int count, input int push_pct);
        for (int i = 0; i < count; i++)
            add_req(($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_TICK, pick_sample());
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || item_valid || expected_results.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_depth(input logic [CFG_W-1:0] raw);
        int eff;
        eff = int'(raw);
        if (eff < MIN_DEPTH)
            eff = MIN_DEPTH;
        else if (eff > DEPTH)
            eff = DEPTH;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= DEPTH_REG_ADDR;
        pwdata <= PDATA_W'(raw);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // A depth write empties the ring but keeps the last sample and the count.
        ring_depth = eff;
        wr_slot = 0;
        play_slot = 0;
    endtask

    initial
    begin
        int raw;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Full-size ring: underrun from reset, extreme samples, drain past empty.
        add_req(REQ_TICK, 16'sh1111);
        add_req(REQ_PUSH, 16'sh7FFF);
        add_req(REQ_PUSH, 16'sh8000);
        add_req(REQ_PUSH, 16'sh0000);
        add_req(REQ_PUSH, 16'shFFFF);
        add_req(REQ_PUSH, 16'sh5A5A);
        repeat (5) add_req(REQ_TICK, 16'shFFFF);
        add_req(REQ_TICK, 16'sh0000);
        wait_idle();

        // Two-slot ring holds one sample, so the second push is dropped.
        write_depth(9'd2);
        @(negedge clk);
        add_req(REQ_PUSH, 16'sh1234);
        add_req(REQ_PUSH, 16'sh5555);
        add_req(REQ_TICK, 16'sh0000);
        add_req(REQ_TICK, 16'sh7FFF);
        add_req(REQ_PUSH, 16'shAAAA);
        add_req(REQ_TICK, 16'sh8000);
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            raw = (depth_plan[p] < 0) ? $urandom_range(511) : depth_plan[p];
            stall_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 25 : 65;
            gap_max = (p % 4 == 0) ? 0 : (p % 4 == 1) ? 3 : (p % 4 == 2) ? 10 : 1;
            write_depth(raw[CFG_W-1:0]);
            @(negedge clk);
            // The receiver goes quiet while the ring is being filled.
            if (p == 2)
                holdoff_ask = HOLDOFF_CYCLES;
            queue_random(half_plan[p], 93);
            wait_idle();
            queue_random(half_plan[p], 12);
            wait_idle();
        end

        // Short mixed run on a small ring.
        write_depth(9'd4);
        stall_pct = 30;
        gap_max = 3;
        @(negedge clk);
        queue_random(60, 50);
        wait_idle();

        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
